// ----- design/sic_pkg.sv -----
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types and codes for the subpath interval clipper.
// ----------------------------------------------------------------------------
package sic_pkg;

	localparam int NAME_W = 10;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_FULL   = 2'd1,
		ST_HIT    = 2'd2,
		ST_NONE   = 2'd3
	} status_t;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// per-cell control: load from the write port, or take the neighbour's entry
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

// ----- design/subpath_interval_clipper_core.sv -----
// ----------------------------------------------------------------------------
// subpath_interval_clipper_core
// Subpath table held in a ring of cells; queries rotate the ring once past
// a two-stage overlap evaluator.
// ----------------------------------------------------------------------------
// Insert: result registered the cycle after the transfer.
// Query: the ring rotates one cell per cycle past cell 0 while not stalled,
//   since each hit needs the previous one to be taken.
// Throughput: one insert per cycle while results are taken; no new request is taken until a query has finished.
// Reset clears the entry count and control; entry contents stay undefined.
module subpath_interval_clipper_core import sic_pkg::*; #(
	parameter int TABLE_DEPTH  = 64,
	parameter int NAME_LIMIT   = 1024,
	parameter int POS_BITS     = 32,
	parameter int PATH_ID_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic                    req_type,
	input  logic [NAME_W-1:0]       name_id,
	input  logic [PATH_ID_BITS-1:0] path_id,
	input  logic [POS_BITS-1:0]     range_start,
	input  logic [POS_BITS-1:0]     range_end,
	input  logic [POS_BITS-1:0]     span_length,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic [1:0]              status,
	output logic [PATH_ID_BITS-1:0] hit_path_id,
	output logic [POS_BITS-1:0]     ovl_start,
	output logic [POS_BITS-1:0]     ovl_end,
	output logic                    last
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q, step_q;
	logic hold_v_q, s1_v, rsp_valid_q;

	// query operands
	logic [NAME_W-1:0]   name_q;
	logic                nok_q;
	logic [POS_BITS-1:0] a_q, b_q;

	// ring
	logic [NAME_W-1:0]       c_name  [TABLE_DEPTH];
	logic [PATH_ID_BITS-1:0] c_path  [TABLE_DEPTH];
	logic [POS_BITS-1:0]     c_start [TABLE_DEPTH];
	logic [POS_BITS:0]       c_end   [TABLE_DEPTH];
	logic [POS_BITS:0]       wr_end;

	// evaluator stage 1 and the held hit
	logic [PATH_ID_BITS-1:0] pid_s1, hold_pid_q;
	logic [POS_BITS-1:0]     lo_s1, hi_s1, st_s1, hold_ls_q, hold_le_q;

	logic accept, is_insert, name_ok, ins_store, out_free, adv;
	logic hit_cand, s1_hit;
	logic [POS_BITS-1:0] lo_c, hi_c;

	logic                    out_load, out_last_d;
	status_t                 out_status_d;
	logic [PATH_ID_BITS-1:0] out_pid_d;
	logic [POS_BITS-1:0]     out_ls_d, out_le_d;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign is_insert = (req_type == REQ_INSERT);
	assign name_ok   = int'(name_id) < NAME_LIMIT;
	assign ins_store = accept && is_insert && name_ok &&
		(count_q != CNT_W'(TABLE_DEPTH));
	assign wr_end    = {1'b0, range_start} + {1'b0, span_length};

	genvar k;
	generate
		for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
			localparam int NXT = (k + 1) % TABLE_DEPTH;
			cell_ctrl_t ctrl;
			assign ctrl.shift = (state_q == S_SCAN) && adv;
			assign ctrl.load  = ins_store && (count_q == CNT_W'(k));
			sic_cell #(
				.POS_BITS    (POS_BITS),
				.PATH_ID_BITS(PATH_ID_BITS)
			) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.wr_name  (name_id),
				.wr_path  (path_id),
				.wr_start (range_start),
				.wr_end   (wr_end),
				.nb_name  (c_name[NXT]),
				.nb_path  (c_path[NXT]),
				.nb_start (c_start[NXT]),
				.nb_end   (c_end[NXT]),
				.ent_name (c_name[k]),
				.ent_path (c_path[k]),
				.ent_start(c_start[k]),
				.ent_end  (c_end[k])
			);
		end
	endgenerate

	// stage 0: clip the entry at cell 0 against the query range
	assign hit_cand = (step_q < count_q) && nok_q && (c_name[0] == name_q);
	assign lo_c     = (a_q > c_start[0]) ? a_q : c_start[0];
	assign hi_c     = ({1'b0, b_q} < c_end[0]) ? b_q : c_end[0][POS_BITS-1:0];

	// stage 1 decides the hit; a new hit pushes the held one out
	assign s1_hit = s1_v && (lo_s1 < hi_s1);
	assign adv    = !(s1_hit && hold_v_q && !out_free);

	always_comb begin
		out_load     = 1'b0;
		out_status_d = ST_NONE;
		out_pid_d    = '0;
		out_ls_d     = '0;
		out_le_d     = '0;
		out_last_d   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept && is_insert) begin
					out_load     = 1'b1;
					out_status_d = ins_store ? ST_STORED : ST_FULL;
				end
			end
			S_SCAN, S_DRAIN: begin
				if (adv && s1_hit && hold_v_q) begin
					out_load     = 1'b1;
					out_status_d = ST_HIT;
					out_pid_d    = hold_pid_q;
					out_ls_d     = hold_ls_q;
					out_le_d     = hold_le_q;
					out_last_d   = 1'b0;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					if (hold_v_q) begin
						out_status_d = ST_HIT;
						out_pid_d    = hold_pid_q;
						out_ls_d     = hold_ls_q;
						out_le_d     = hold_le_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			hold_v_q    <= 1'b0;
			s1_v        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (ins_store)
						count_q <= count_q + 1'b1;
					if (accept && !is_insert) begin
						state_q  <= S_SCAN;
						step_q   <= '0;
						hold_v_q <= 1'b0;
						s1_v     <= 1'b0;
					end
				end
				S_SCAN: begin
					if (adv) begin
						s1_v   <= hit_cand;
						step_q <= step_q + 1'b1;
						if (s1_hit)
							hold_v_q <= 1'b1;
						if (step_q == CNT_W'(TABLE_DEPTH - 1))
							state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (adv) begin
						s1_v <= 1'b0;
						if (s1_hit)
							hold_v_q <= 1'b1;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						hold_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && !is_insert) begin
			name_q <= name_id;
			nok_q  <= name_ok;
			a_q    <= range_start;
			b_q    <= range_end;
		end
		if (state_q == S_SCAN && adv) begin
			pid_s1 <= c_path[0];
			lo_s1  <= lo_c;
			hi_s1  <= hi_c;
			st_s1  <= c_start[0];
		end
		if (adv && s1_hit) begin
			hold_pid_q <= pid_s1;
			hold_ls_q  <= lo_s1 - st_s1;
			hold_le_q  <= hi_s1 - st_s1;
		end
		if (out_load) begin
			status      <= out_status_d;
			hit_path_id <= out_pid_d;
			ovl_start   <= out_ls_d;
			ovl_end     <= out_le_d;
			last        <= out_last_d;
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(count_q))
		else $error("entry count moved during a query");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!hold_v_q && !s1_v))
		else $error("hit pipeline busy while idle");

	a_mid_is_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !last) |-> (status == ST_HIT))
		else $error("non-final result that is not a hit");

	a_hit_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status == ST_HIT) |-> (ovl_start < ovl_end))
		else $error("empty overlap reported");

endmodule

// ----- design/sic_cell.sv -----
// ----------------------------------------------------------------------------
// sic_cell
// One table entry of the ring; loads a new entry or takes its neighbour's.
// ----------------------------------------------------------------------------
module sic_cell import sic_pkg::*; #(
	parameter int POS_BITS     = 32,
	parameter int PATH_ID_BITS = 24
) (
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic [NAME_W-1:0]       wr_name,
	input  logic [PATH_ID_BITS-1:0] wr_path,
	input  logic [POS_BITS-1:0]     wr_start,
	input  logic [POS_BITS:0]       wr_end,
	input  logic [NAME_W-1:0]       nb_name,
	input  logic [PATH_ID_BITS-1:0] nb_path,
	input  logic [POS_BITS-1:0]     nb_start,
	input  logic [POS_BITS:0]       nb_end,
	output logic [NAME_W-1:0]       ent_name,
	output logic [PATH_ID_BITS-1:0] ent_path,
	output logic [POS_BITS-1:0]     ent_start,
	output logic [POS_BITS:0]       ent_end
);

	logic [NAME_W-1:0]       name_q;
	logic [PATH_ID_BITS-1:0] path_q;
	logic [POS_BITS-1:0]     start_q;
	logic [POS_BITS:0]       end_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			name_q  <= nb_name;
			path_q  <= nb_path;
			start_q <= nb_start;
			end_q   <= nb_end;
		end else if (ctrl.load) begin
			name_q  <= wr_name;
			path_q  <= wr_path;
			start_q <= wr_start;
			end_q   <= wr_end;
		end
	end

	assign ent_name  = name_q;
	assign ent_path  = path_q;
	assign ent_start = start_q;
	assign ent_end   = end_q;

endmodule

// ----- verif/subpath_interval_clipper_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subpath_interval_clipper_core_test
// Self-checking bench for the subpath interval clipper. Requests are driven
// with random gaps and results are taken with random stalls. A local copy of
// the subpath table predicts the outcome of every insert and every clipped
// overlap, and each result transfer is checked in order against it.
// ----------------------------------------------------------------------------
module subpath_interval_clipper_core_test;
	import sic_pkg::*;

	localparam int DEPTH      = 64;
	localparam int NAME_LIM   = 1024;
	localparam int POS_W      = 32;
	localparam int PID_W      = 24;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYC  = DEPTH + 16;

	typedef struct {
		logic              kind;
		logic [NAME_W-1:0] name;
		logic [PID_W-1:0]  pid;
		logic [POS_W-1:0]  a;
		logic [POS_W-1:0]  b;
		logic [POS_W-1:0]  len;
	} span_req_t;

	typedef struct {
		status_t          code;
		logic [PID_W-1:0] pid;
		logic [POS_W-1:0] lo_off;
		logic [POS_W-1:0] hi_off;
		logic             fin;
	} clip_result_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	logic              req_type;
	logic [NAME_W-1:0] name_id;
	logic [PID_W-1:0]  path_id;
	logic [POS_W-1:0]  range_start;
	logic [POS_W-1:0]  range_end;
	logic [POS_W-1:0]  span_length;
	logic              rsp_valid;
	logic              rsp_ready;
	logic [1:0]        status;
	logic [PID_W-1:0]  hit_path_id;
	logic [POS_W-1:0]  ovl_start;
	logic [POS_W-1:0]  ovl_end;
	logic              last;

	// shadow of the subpath table
	logic [NAME_W-1:0] tbl_name [DEPTH];
	logic [PID_W-1:0]  tbl_path [DEPTH];
	logic [POS_W-1:0]  tbl_start [DEPTH];
	logic [POS_W-1:0]  tbl_len [DEPTH];
	int                tbl_count;

	clip_result_t      pending_clips[$];

	int  mismatches;
	int  idle_cycles;
	int  n_inserts, n_queries, n_rejected, n_results, n_hits, n_misses;
	bit  req_steady, rsp_steady;

	subpath_interval_clipper_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.name_id     (name_id),
		.path_id     (path_id),
		.range_start (range_start),
		.range_end   (range_end),
		.span_length (span_length),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.hit_path_id (hit_path_id),
		.ovl_start   (ovl_start),
		.ovl_end     (ovl_end),
		.last        (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH %0d at %0t: %s", mismatches + 1, $realtime, what);
		mismatches++;
	endtask

	// table update and overlap clipping for one accepted request
	task automatic clip_predict(input span_req_t r);
		clip_result_t res;
		clip_result_t found[$];
		logic [POS_W:0] s, e, lo, hi, d_lo, d_hi;
		res.code   = ST_STORED;
		res.pid    = '0;
		res.lo_off = '0;
		res.hi_off = '0;
		res.fin    = 1'b1;
		if (r.kind == REQ_INSERT) begin
			n_inserts++;
			if (tbl_count >= DEPTH || int'(r.name) >= NAME_LIM) begin
				res.code = ST_FULL;
				n_rejected++;
			end else begin
				tbl_name[tbl_count]  = r.name;
				tbl_path[tbl_count]  = r.pid;
				tbl_start[tbl_count] = r.a;
				tbl_len[tbl_count]   = r.len;
				tbl_count++;
			end
			pending_clips = {pending_clips, res};
		end else begin
			n_queries++;
			if (int'(r.name) < NAME_LIM) begin
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_name[i] == r.name) begin
						// span end is one bit wider so it cannot wrap
						s  = {1'b0, tbl_start[i]};
						e  = s + {1'b0, tbl_len[i]};
						lo = ({1'b0, r.a} > s) ? {1'b0, r.a} : s;
						hi = ({1'b0, r.b} < e) ? {1'b0, r.b} : e;
						if (lo < hi) begin
							d_lo       = lo - s;
							d_hi       = hi - s;
							res.code   = ST_HIT;
							res.pid    = tbl_path[i];
							res.lo_off = d_lo[POS_W-1:0];
							res.hi_off = d_hi[POS_W-1:0];
							res.fin    = 1'b0;
							found      = {found, res};
						end
					end
				end
			end
			if (found.size() == 0) begin
				res.code = ST_NONE;
				res.fin  = 1'b1;
				pending_clips = {pending_clips, res};
			end else begin
				found[found.size() - 1].fin = 1'b1;
				foreach (found[k])
					pending_clips = {pending_clips, found[k]};
			end
		end
	endtask

	function automatic span_req_t mk_insert(input logic [NAME_W-1:0] nm,
			input logic [PID_W-1:0] pid, input logic [POS_W-1:0] st,
			input logic [POS_W-1:0] len);
		span_req_t r;
		r.kind = REQ_INSERT;
		r.name = nm;
		r.pid  = pid;
		r.a    = st;
		r.b    = '1;
		r.len  = len;
		return r;
	endfunction

	function automatic span_req_t mk_query(input logic [NAME_W-1:0] nm,
			input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
		span_req_t r;
		r.kind = REQ_QUERY;
		r.name = nm;
		r.pid  = '1;
		r.a    = a;
		r.b    = b;
		r.len  = '1;
		return r;
	endfunction

	// one request transfer, after a random gap
	task automatic send_item(input span_req_t r);
		int gap;
		gap = req_steady ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid   <= 1'b1;
		req_type    <= r.kind;
		name_id     <= r.name;
		path_id     <= r.pid;
		range_start <= r.a;
		range_end   <= r.b;
		span_length <= r.len;
		do @(posedge clk); while (req_ready !== 1'b1);
		clip_predict(r);
	endtask

	task automatic test_empty_table;
		send_item(mk_query('0, '0, '1));
		send_item(mk_query('1, 32'd5, 32'd6));
	endtask

	task automatic test_insert_extremes;
		send_item(mk_insert('0, '0, '0, '0));                 // zero length
		send_item(mk_insert('1, '1, '1, '1));                 // span past the top
		send_item(mk_insert(10'd5, 24'h5A5A5A, 32'd1000, 32'd500));
		send_item(mk_insert(10'd5, 24'hA5A5A5, 32'd1200, 32'd100));
		send_item(mk_insert(10'd5, 24'h000123, 32'd0, 32'hFFFF_FFFF));
		send_item(mk_insert('1, 24'h800001, 32'h8000_0000, 32'hFFFF_FFFF));
	endtask

	task automatic test_query_edges;
		send_item(mk_query(10'd5, 32'd1100, 32'd1250));       // several hits
		send_item(mk_query(10'd5, 32'd1250, 32'd1250));       // empty range
		send_item(mk_query(10'd5, 32'd2000, 32'd1000));       // reversed range
		send_item(mk_query(10'd5, 32'd1500, 32'd1600));       // touches an end
		send_item(mk_query('0, '0, '1));                      // zero length entry
		send_item(mk_query('1, 32'hFFFF_FFF0, 32'hFFFF_FFFF));
		send_item(mk_query('1, '0, '1));
		send_item(mk_query(10'd6, '0, '1));                   // unknown name
		send_item(mk_query(10'd5, '0, '1));
	endtask

	task automatic test_random_traffic(input int count);
		logic [NAME_W-1:0] pool [4];
		span_req_t         r;
		logic [NAME_W-1:0] nm;
		logic [POS_W-1:0]  st, len, a, b;
		int                idx, pick;
		foreach (pool[i])
			pool[i] = NAME_W'($urandom);
		for (int k = 0; k < count; k++) begin
			if (k % 32 == 0)
				req_steady = ($urandom_range(0, 3) == 0);
			nm = ($urandom_range(0, 7) == 0) ? NAME_W'($urandom) : pool[$urandom_range(0, 3)];
			if ($urandom_range(0, (tbl_count < DEPTH) ? 4 : 11) == 0) begin
				case ($urandom_range(0, 9))
					0:       st = $urandom;
					1:       st = 32'hFFFF_FFFF - $urandom_range(0, 300);
					default: st = $urandom_range(0, 4000);
				endcase
				case ($urandom_range(0, 11))
					0:       len = '0;
					1:       len = $urandom;
					2:       len = '1;
					default: len = $urandom_range(1, 200);
				endcase
				r   = mk_insert(nm, PID_W'($urandom), st, len);
				r.b = $urandom;
			end else begin
				pick = (tbl_count == 0) ? 0 : $urandom_range(0, 11);
				case (pick)
					0: begin
						a = $urandom;
						b = $urandom;
					end
					1: begin
						a = '0;
						b = '1;
					end
					default: begin
						idx = $urandom_range(0, tbl_count - 1);
						nm  = tbl_name[idx];
						a   = tbl_start[idx] - $urandom_range(0, 100);
						b   = a + $urandom_range(0, 350);
						if (pick == 2) begin
							st = a;
							a  = b;
							b  = st;
						end
					end
				endcase
				r     = mk_query(nm, a, b);
				r.pid = PID_W'($urandom);
				r.len = $urandom;
			end
			send_item(r);
		end
		req_steady = 1'b0;
	endtask

	task automatic test_table_full;
		logic [NAME_W-1:0] nm;
		nm = 10'h2A5;
		while (tbl_count < DEPTH)
			send_item(mk_insert(nm, PID_W'(tbl_count), 32'(tbl_count * 16), 32'd40));
		send_item(mk_insert(nm, '1, 32'd10, 32'd10));
		send_item(mk_insert('0, 24'h00ABCD, '0, 32'd1));
		send_item(mk_insert('1, '0, '1, '0));
		send_item(mk_query(nm, '0, '1));
		send_item(mk_query(nm, 32'd100, 32'd400));
		send_item(mk_query(tbl_name[0], '0, '1));
	endtask

	// response side: random stall before each transfer
	initial begin
		int stall, taken;
		rsp_ready  = 1'b0;
		rsp_steady = 1'b0;
		taken      = 0;
		@(posedge arst_n);
		forever begin
			if (taken % 40 == 0)
				rsp_steady = ($urandom_range(0, 3) == 0);
			stall = rsp_steady ? 0 : $urandom_range(0, 6);
			repeat (stall) begin
				@(negedge clk);
				rsp_ready <= 1'b0;
			end
			@(negedge clk);
			rsp_ready <= 1'b1;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			taken++;
		end
	end

	// result check against the oldest outstanding prediction
	always @(posedge clk) begin
		clip_result_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			n_results++;
			if (status == ST_HIT)
				n_hits++;
			if (status == ST_NONE)
				n_misses++;
			if (pending_clips.size() == 0) begin
				report_mismatch($sformatf("unexpected result, status %0d", status));
			end else begin
				want = pending_clips.pop_front();
				if (status !== want.code)
					report_mismatch($sformatf("status %0d, want %0d", status, want.code));
				if (hit_path_id !== want.pid)
					report_mismatch($sformatf("path id %h, want %h", hit_path_id, want.pid));
				if (ovl_start !== want.lo_off)
					report_mismatch($sformatf("overlap start %h, want %h",
						ovl_start, want.lo_off));
				if (ovl_end !== want.hi_off)
					report_mismatch($sformatf("overlap end %h, want %h", ovl_end, want.hi_off));
				if (last !== want.fin)
					report_mismatch($sformatf("last %b, want %b", last, want.fin));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, pending_clips.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req_type    = REQ_INSERT;
		name_id     = '0;
		path_id     = '0;
		range_start = '0;
		range_end   = '0;
		span_length = '0;
		req_steady  = 1'b0;
		tbl_count   = 0;
		mismatches  = 0;
		idle_cycles = 0;
		n_inserts   = 0;
		n_queries   = 0;
		n_rejected  = 0;
		n_results   = 0;
		n_hits      = 0;
		n_misses    = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_insert_extremes();
		test_query_edges();
		test_random_traffic(420);
		test_table_full();

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_clips.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("run: %0d inserts (%0d refused), %0d queries, table holds %0d",
			n_inserts, n_rejected, n_queries, tbl_count);
		$display("run: %0d results checked, %0d overlap hits, %0d empty queries, %0d errors",
			n_results, n_hits, n_misses, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
